[rtl/core/rsq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants of the r squared accumulator: controller states,
// command and status bundles between controller and datapath, result codes.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int R_W     = 32;
    localparam int STS_W   = 2;
    localparam int QUOT_BITS = 32;

    localparam logic [STS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STATUS_ZERO_VAR = 2'd1;
    localparam logic [STS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // signed q15.16 codes
    localparam logic [R_W-1:0] R2_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [R_W-1:0] R2_ONE       = 32'h0001_0000;
    localparam logic [R_W-1:0] R2_SAT_MIN   = 32'h8000_0000;
    // largest quotient that still fits after one minus q
    localparam logic [QUOT_BITS-1:0] Q_SAT_LIMIT = 32'h8001_0000;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_CHECK,
        ST_MUL_DEN,
        ST_MUL_SUM,
        ST_MUL_RES,
        ST_CMP,
        ST_DIV,
        ST_FINISH,
        ST_RESULT
    } ctl_state_t;

    typedef enum logic [1:0] {
        MUL_N_SUMSQ,
        MUL_SUM_SQ,
        MUL_N_RESSQ
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_OVERFLOW,
        RES_ZERO_VAR,
        RES_SATURATE,
        RES_QUOTIENT
    } res_kind_t;

    typedef struct packed {
        logic      in_take;
        logic      acc_clear;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      den_load;
        logic      den_sub;
        logic      num_load;
        logic      div_init;
        logic      div_step;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic last_commit;
        logic overflow;
        logic mul_done;
        logic den_zero;
        logic quot_big;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/rsq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_datapath
// Sample pipeline with running sums, a shift-add multiplier shared by the
// three end-of-set products, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module rsq_datapath import rsq_pkg::*; #(
    parameter int MAX_ITEMS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire  signed [SAMPLE_BITS-1:0] in_true,
    input  wire  signed [SAMPLE_BITS-1:0] in_pred,
    input  wire                           in_last,
    input  wire  ctl_cmd_t                cmd,
    output dp_status_t                    sts,
    input  wire                           out_ready,
    output logic                          out_valid,
    output logic [R_W-1:0]                out_r_squared,
    output logic [STS_W-1:0]              out_status
);

    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int SQW  = 2 * SAMPLE_BITS + CW;
    localparam int PW   = 2 * SAMPLE_BITS + 2 * CW;
    localparam int DSW  = PW + 33;
    localparam int QCW  = $clog2(QUOT_BITS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    // stage 1: captured samples
    logic                          v1_reg;
    logic                          last1_reg;
    logic signed [SAMPLE_BITS-1:0] t1_reg;
    logic signed [SAMPLE_BITS-1:0] p1_reg;

    // stage 2: squares
    logic                          v2_reg;
    logic                          last2_reg;
    logic signed [SAMPLE_BITS-1:0] t2_reg;
    logic [2*SAMPLE_BITS-1:0]      tt2_reg;
    logic [2*SAMPLE_BITS-1:0]      dd2_reg;

    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [2*SAMPLE_BITS-1:0] tt_full;
    logic signed [2*SAMPLE_BITS+1:0] dd_full;

    // accumulators
    logic [CW-1:0]          count_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [SQW-1:0]         sumsq_reg;
    logic [SQW-1:0]         ressq_reg;
    logic                   overflow_reg;

    // end-of-set arithmetic
    logic [PW-1:0]        mcand_reg;
    logic [SUMW-1:0]      mplier_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        den_reg;
    logic [DSW-1:0]       num_reg;
    logic [DSW-1:0]       dsh_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic [QCW-1:0]       step_reg;
    logic [R_W-1:0]       res_r_reg;
    logic [STS_W-1:0]     res_st_reg;
    logic [SUMW-1:0]      sum_mag;

    assign diff    = {t1_reg[SAMPLE_BITS-1], t1_reg} - {p1_reg[SAMPLE_BITS-1], p1_reg};
    assign tt_full = t1_reg * t1_reg;
    assign dd_full = diff * diff;
    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.in_take;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_take) begin
            t1_reg    <= in_true;
            p1_reg    <= in_pred;
            last1_reg <= in_last;
        end
        t2_reg    <= t1_reg;
        last2_reg <= last1_reg;
        tt2_reg   <= tt_full;
        dd2_reg   <= dd_full[2*SAMPLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clear) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            ressq_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (v2_reg) begin
            if (count_reg == MAX_CNT) begin
                overflow_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUMW'(t2_reg);
                sumsq_reg <= sumsq_reg + SQW'(tt2_reg);
                ressq_reg <= ressq_reg + SQW'(dd2_reg);
            end
        end
    end

    // shift-add multiplier, stops early once the multiplier runs out of ones
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            prod_reg <= '0;
            case (cmd.mul_sel)
                MUL_N_SUMSQ: begin
                    mcand_reg  <= PW'(sumsq_reg);
                    mplier_reg <= SUMW'(count_reg);
                end
                MUL_SUM_SQ: begin
                    mcand_reg  <= PW'(sum_mag);
                    mplier_reg <= sum_mag;
                end
                MUL_N_RESSQ: begin
                    mcand_reg  <= PW'(ressq_reg);
                    mplier_reg <= SUMW'(count_reg);
                end
                default: begin
                    mcand_reg  <= '0;
                    mplier_reg <= '0;
                end
            endcase
        end else if (mplier_reg != '0) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    // n*sumsq - sum^2, never negative
    always_ff @(posedge aclk) begin
        if (cmd.den_load) begin
            den_reg <= prod_reg;
        end else if (cmd.den_sub) begin
            den_reg <= den_reg - prod_reg;
        end
    end

    // restoring division of (a*2^17 + den) by 2*den, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.num_load) begin
            num_reg <= DSW'({prod_reg, 17'b0}) + DSW'(den_reg);
        end else if (cmd.div_step) begin
            if (num_reg >= dsh_reg) begin
                num_reg <= num_reg - dsh_reg;
                q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b0};
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.div_init) begin
            dsh_reg  <= DSW'({den_reg, 32'b0});
            q_reg    <= '0;
            step_reg <= QCW'(QUOT_BITS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            case (cmd.res_kind)
                RES_OVERFLOW: begin
                    res_r_reg  <= R2_MINUS_ONE;
                    res_st_reg <= STATUS_OVERFLOW;
                end
                RES_ZERO_VAR: begin
                    res_r_reg  <= R2_MINUS_ONE;
                    res_st_reg <= STATUS_ZERO_VAR;
                end
                RES_SATURATE: begin
                    res_r_reg  <= R2_SAT_MIN;
                    res_st_reg <= STATUS_OK;
                end
                RES_QUOTIENT: begin
                    res_r_reg  <= (q_reg > Q_SAT_LIMIT) ? R2_SAT_MIN : R2_ONE - q_reg;
                    res_st_reg <= STATUS_OK;
                end
                default: begin
                    res_r_reg  <= R2_MINUS_ONE;
                    res_st_reg <= STATUS_OK;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_r_squared <= res_r_reg;
            out_status    <= res_st_reg;
        end
    end

    always_comb begin
        sts.last_commit = v2_reg && last2_reg;
        sts.overflow    = overflow_reg;
        sts.mul_done    = (mplier_reg == '0);
        sts.den_zero    = (den_reg == '0);
        sts.quot_big    = (num_reg >= {den_reg, 33'b0});
        sts.div_last    = (step_reg == '0);
        sts.out_free    = !out_valid || out_ready;
    end

endmodule
`default_nettype wire

[rtl/core/rsq_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_controller
// Sequencer: takes pairs until the last one, then steps the datapath via the
// overflow check, three products, zero-variance check, division and result.
// ----------------------------------------------------------------------------
module rsq_controller import rsq_pkg::*; (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_axis_tvalid,
    input  wire             s_axis_tlast,
    output logic            s_axis_tready,
    input  wire dp_status_t sts,
    output ctl_cmd_t        cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_axis_tready = 1'b1;
                cmd.in_take   = s_axis_tvalid;
                if (s_axis_tvalid && s_axis_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.last_commit) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.overflow) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_OVERFLOW;
                    state_next   = ST_RESULT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_N_SUMSQ;
                    state_next    = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN: begin
                if (sts.mul_done) begin
                    cmd.den_load  = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SUM_SQ;
                    state_next    = ST_MUL_SUM;
                end
            end
            ST_MUL_SUM: begin
                if (sts.mul_done) begin
                    cmd.den_sub   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_N_RESSQ;
                    state_next    = ST_MUL_RES;
                end
            end
            ST_MUL_RES: begin
                if (sts.mul_done) begin
                    if (sts.den_zero) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_ZERO_VAR;
                        state_next   = ST_RESULT;
                    end else begin
                        cmd.num_load = 1'b1;
                        state_next   = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                // quotient of 2^32 or more saturates without dividing
                if (sts.quot_big) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_SATURATE;
                    state_next   = ST_RESULT;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_QUOTIENT;
                state_next   = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/r_squared_accumulator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// r_squared_accumulator_unit
// Coefficient of determination over sets of (true, predicted) sample pairs.
//
// Input stream: one pair per transaction, true and predicted value as signed
// fixed point samples in s_axis_tdata, s_axis_tlast marks the last pair of a
// set. Pairs are taken at one per cycle while a set is open.
// Output stream: one transaction per set, r squared as signed q15.16 in
// m_axis_tdata and the status code in m_axis_tuser (0 valid, 1 zero variance,
// 2 more pairs than MAX_ITEMS). Error results carry -1.0.
// After the last pair the input stalls while the result is computed: the
// sample pipeline drains, the overflow flag is checked, the shared shift-add
// multiplier forms its products with n, |sum| and n again as multiplier, each
// until the multiplier runs out of ones, then a compare, the restoring
// division and the forming and loading of the result lead to m_axis_tvalid.
// Overflow skips the products, compare and division; zero variance skips the
// latter two. The next set opens once the result sits in the output register;
// a stalled receiver holds it there, and a following result waits until it is
// taken. Reset (aresetn low, synchronous) clears sums and count, drops tvalid.
// ----------------------------------------------------------------------------
module r_squared_accumulator_unit import rsq_pkg::*; #(
    parameter int MAX_ITEMS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        s_axis_tvalid,
    output logic                                       s_axis_tready,
    // true_value, predicted_value
    input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  wire                                        s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire                                        m_axis_tready,
    // r_squared
    output logic [R_W-1:0]                             m_axis_tdata,
    // status
    output logic [STS_W-1:0]                           m_axis_tuser
);

    ctl_cmd_t   cmd;
    dp_status_t sts;

    rsq_controller u_ctl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    rsq_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_true       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_pred       (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_last       (s_axis_tlast),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_r_squared (m_axis_tdata),
        .out_status    (m_axis_tuser)
    );

endmodule
`default_nettype wire

[sim/r_squared_accumulator_unit_tb.sv]
// ----------------------------------------------------------------------------
// r_squared_accumulator_unit_tb
// Self-checking bench for the r squared accumulator. Sets of (true, predicted)
// pairs are streamed in with random gaps. The bench keeps its own running sums,
// computes the expected r squared and status at each last pair, and compares
// every output transaction in order. It covers directed corner sets, random
// sets, and long receiver stalls that back up the input.
// ----------------------------------------------------------------------------
module r_squared_accumulator_unit_tb;
    import rsq_pkg::*;

    localparam int          PAIR_LIMIT  = 65536;
    localparam int          SAMPLE_W    = 16;
    localparam int          RANDOM_PAIRS = 1250;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES = 200;
    localparam logic [15:0] S_MIN = 16'h8000;
    localparam logic [15:0] S_MAX = 16'h7FFF;

    typedef struct {
        logic [15:0] true_v;
        logic [15:0] pred_v;
        logic        last;
        int unsigned max_gap;
    } pair_item_t;

    typedef struct {
        logic [R_W-1:0]   r2;
        logic [STS_W-1:0] status;
    } r2_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;
    logic             s_axis_tlast = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [R_W-1:0]   m_axis_tdata;
    logic [STS_W-1:0] m_axis_tuser;

    r_squared_accumulator_unit #(
        .MAX_ITEMS  (PAIR_LIMIT),
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pair_item_t pair_q[$];
    r2_result_t r2_expect_q[$];
    int         error_count = 0;

    // running sums of the open set
    int unsigned  set_count = 0;
    longint       true_total = 0;
    logic [127:0] true_sq_total = '0;
    logic [127:0] resid_sq_total = '0;
    bit           set_overflow = 1'b0;

    task automatic accumulate_pair(input logic [15:0] true_raw, input logic [15:0] pred_raw,
                                   input logic last);
        longint       tv;
        longint       rv;
        logic [127:0] sum_mag;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] quo;
        r2_result_t   res;
        tv = longint'($signed(true_raw));
        rv = tv - longint'($signed(pred_raw));
        if (set_count >= PAIR_LIMIT) begin
            set_overflow = 1'b1;
        end else begin
            set_count++;
            true_total += tv;
            true_sq_total += 128'(tv * tv);
            resid_sq_total += 128'(rv * rv);
        end
        if (!last) return;
        res.r2 = R2_MINUS_ONE;
        if (set_overflow) begin
            res.status = STATUS_OVERFLOW;
        end else begin
            sum_mag = 128'((true_total < 0) ? -true_total : true_total);
            den = true_sq_total * set_count - sum_mag * sum_mag;
            if (den == 0) begin
                res.status = STATUS_ZERO_VAR;
            end else begin
                // round to nearest, ties up: (2a + d) / 2d scaled by 2^16
                num = ((resid_sq_total * set_count) << 17) + den;
                quo = num / (den << 1);
                res.status = STATUS_OK;
                if (quo > 128'(Q_SAT_LIMIT))
                    res.r2 = R2_SAT_MIN;
                else
                    res.r2 = 32'(128'd65536 - quo);
            end
        end
        r2_expect_q.push_back(res);
        set_count = 0;
        true_total = 0;
        true_sq_total = '0;
        resid_sq_total = '0;
        set_overflow = 1'b0;
    endtask

    task automatic push_pair(input logic [15:0] t, input logic [15:0] p, input logic last,
                             input int unsigned max_gap);
        pair_item_t item;
        item.true_v = t;
        item.pred_v = p;
        item.last = last;
        item.max_gap = max_gap;
        pair_q.push_back(item);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return S_MIN;
            1: return S_MAX;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // one set of len pairs, content shaped by style
    task automatic add_set(input int unsigned len, input int unsigned style,
                           input int unsigned max_gap);
        logic [15:0] t;
        logic [15:0] p;
        logic [15:0] base;
        base = 16'($urandom());
        for (int unsigned i = 0; i < len; i++) begin
            t = 16'($urandom());
            p = 16'($urandom());
            case (style)
                1: p = t + 16'($urandom_range(0, 64)) - 16'd32;
                2: t = base;
                3: t = base + 16'($urandom_range(0, 8)) - 16'd4;
                4: begin
                    t = pick_extreme();
                    p = pick_extreme();
                end
                5: p = -t;
                default: ;
            endcase
            push_pair(t, p, i == len - 1, max_gap);
        end
    endtask

    // driver
    pair_item_t  cur_pair;
    int unsigned gap_left = 0;
    logic        drive_valid;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            drive_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_pair(cur_pair.true_v, cur_pair.pred_v, cur_pair.last);
                drive_valid = 1'b0;
                gap_left = $urandom_range(0, cur_pair.max_gap);
            end
            if (!drive_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pair_q.size() != 0) begin
                    cur_pair = pair_q.pop_front();
                    s_axis_tdata <= {cur_pair.pred_v, cur_pair.true_v};
                    s_axis_tlast <= cur_pair.last;
                    drive_valid = 1'b1;
                end
            end
            s_axis_tvalid <= drive_valid;
        end
    end

    // receiver hold-off, starts once enough results have come
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 20;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            next_hold_at <= 20;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= next_hold_at) begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 60;
        end
    end

    // monitor
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    r2_result_t  want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            results_seen <= 0;
            stall_left = 0;
            calm_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (r2_expect_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected transaction r2=%h status=%0d", $time,
                             m_axis_tdata, m_axis_tuser);
                end else begin
                    want = r2_expect_q.pop_front();
                    if (m_axis_tdata !== want.r2) begin
                        error_count++;
                        $display("%0t: r2 mismatch expected %h actual %h", $time,
                                 want.r2, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.status) begin
                        error_count++;
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 want.status, m_axis_tuser);
                    end
                end
                results_seen <= results_seen + 1;
                if (calm_left != 0) begin
                    calm_left--;
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 8);
                    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 30);
                end
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    initial begin
        #(8 * 1_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned queued;
        int unsigned len;

        // directed corner sets
        push_pair(S_MAX, S_MIN, 1'b1, 8);              // single pair, zero variance
        push_pair(S_MIN, S_MIN, 1'b0, 8);              // perfect prediction
        push_pair(S_MAX, S_MAX, 1'b1, 8);
        push_pair(16'h0000, S_MAX, 1'b0, 8);           // tiny variance, huge error
        push_pair(16'h0001, S_MIN, 1'b1, 8);
        push_pair(S_MIN, S_MAX, 1'b0, 8);              // anti-correlated, negative r2
        push_pair(S_MAX, S_MIN, 1'b0, 8);
        push_pair(16'h0000, 16'h0000, 1'b1, 8);
        push_pair(16'hFFFE, 16'h0000, 1'b0, 8);        // predicting the mean, r2 zero
        push_pair(16'h0002, 16'h0000, 1'b1, 8);
        push_pair(16'h0100, S_MAX, 1'b0, 8);           // constant true values
        push_pair(16'h0100, S_MIN, 1'b0, 8);
        push_pair(16'h0100, 16'h0000, 1'b0, 8);
        push_pair(16'h0100, 16'hFFFF, 1'b1, 8);
        push_pair(16'hFFFF, 16'h0001, 1'b0, 8);
        push_pair(16'h0001, 16'hFFFF, 1'b0, 8);
        push_pair(16'h5555, 16'hAAAA, 1'b0, 8);
        push_pair(16'hAAAA, 16'h5555, 1'b1, 8);

        queued = 0;
        while (queued < RANDOM_PAIRS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300)
                                              : $urandom_range(1, 16);
            add_set(len, $urandom_range(0, 5), ($urandom_range(0, 3) == 0) ? 0 : 8);
            queued += len;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_axis_tvalid || r2_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/rsq_pkg.sv
rtl/core/rsq_datapath.sv
rtl/core/rsq_controller.sv
rtl/core/r_squared_accumulator_unit.sv
sim/r_squared_accumulator_unit_tb.sv
